// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// File: rtl/bpq_pkg.sv
// ---------------------------------------------------------------------------
// bpq_pkg
// Command and status codes, defaults and shared types of the bucket queue.
// ---------------------------------------------------------------------------
package bpq_pkg;

	localparam int DEF_NODE_COUNT = 1024;
	localparam int DEF_TOP_BUCKET = 1023;
	localparam int HOP_W          = 8;

	localparam logic [1:0] CMD_INSERT   = 2'd0;
	localparam logic [1:0] CMD_DECREASE = 2'd1;
	localparam logic [1:0] CMD_DELETE   = 2'd2;
	localparam logic [1:0] CMD_LOOKUP   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_DUP    = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// Field write enables of the node memory
	typedef struct packed {
		logic rec;
		logic nxt;
		logic prv;
	} node_we_t;

endpackage

// File: rtl/bpq_store.sv
// ---------------------------------------------------------------------------
// bpq_store
// Node record memory with per-field write lanes, and bucket head memory.
// One write and one registered read per memory per cycle.
// ---------------------------------------------------------------------------
module bpq_store #(
	parameter int NODE_COUNT = bpq_pkg::DEF_NODE_COUNT,
	parameter int TOP_BUCKET = bpq_pkg::DEF_TOP_BUCKET
) (
	input  logic                                         clk,
	input  logic [$clog2(NODE_COUNT)-1:0]                node_raddr,
	input  logic [$clog2(NODE_COUNT)-1:0]                node_waddr,
	input  bpq_pkg::node_we_t                            node_we,
	input  logic [2+$clog2(TOP_BUCKET+1)+bpq_pkg::HOP_W-1:0] node_wrec,
	input  logic [$clog2(NODE_COUNT+1)-1:0]              node_wnext,
	input  logic [$clog2(NODE_COUNT+1)-1:0]              node_wprev,
	output logic [2+$clog2(TOP_BUCKET+1)+bpq_pkg::HOP_W-1:0] node_rrec,
	output logic [$clog2(NODE_COUNT+1)-1:0]              node_rnext,
	output logic [$clog2(NODE_COUNT+1)-1:0]              node_rprev,
	input  logic [$clog2(TOP_BUCKET+1)-1:0]              head_raddr,
	input  logic [$clog2(TOP_BUCKET+1)-1:0]              head_waddr,
	input  logic                                         head_we,
	input  logic [$clog2(NODE_COUNT+1)-1:0]              head_wdata,
	output logic [$clog2(NODE_COUNT+1)-1:0]              head_rdata
);
	import bpq_pkg::*;

	localparam int PTR_W = $clog2(NODE_COUNT+1);
	localparam int B_W   = $clog2(TOP_BUCKET+1);
	localparam int REC_W = 2 + B_W + HOP_W;

	logic [REC_W-1:0] rec_mem  [NODE_COUNT];
	logic [PTR_W-1:0] next_mem [NODE_COUNT];
	logic [PTR_W-1:0] prev_mem [NODE_COUNT];
	logic [PTR_W-1:0] head_mem [TOP_BUCKET+1];

	// Write the enabled lanes, read the addressed word
	always_ff @(posedge clk) begin
		if (node_we.rec) begin
			rec_mem[node_waddr] <= node_wrec;
		end
		if (node_we.nxt) begin
			next_mem[node_waddr] <= node_wnext;
		end
		if (node_we.prv) begin
			prev_mem[node_waddr] <= node_wprev;
		end
		node_rrec  <= rec_mem[node_raddr];
		node_rnext <= next_mem[node_raddr];
		node_rprev <= prev_mem[node_raddr];
	end

	// Bucket heads
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rdata <= head_mem[head_raddr];
	end

endmodule

// File: rtl/bucket_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// bucket_priority_queue_unit
// Dial-style bucket queue: per-distance doubly linked lists in memory.
// ---------------------------------------------------------------------------
// After reset the unit sweeps its memories over max(NODE_COUNT, TOP_BUCKET+1)
// addresses (1024 by default) with s_tready low. Each request returns one
// result. Lookup and rejected requests need no more than the read state before
// the result register; insert puts the node at the head of its bucket and, if
// that bucket was not empty, fixes the old head's back link; a decrease key that
// moves a queued node first unlinks it and then pushes it the same way. Delete
// minimum walks the bucket head memory one bucket per cycle, first to find the
// minimum and then from its bucket on to find the next one. A new request is
// taken while a finished result waits.
module bucket_priority_queue_unit #(
	parameter int NODE_COUNT = bpq_pkg::DEF_NODE_COUNT,
	parameter int TOP_BUCKET = bpq_pkg::DEF_TOP_BUCKET
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // node_id[9:0], distance_in[19:10], links_in[27:20]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_id[9:0], result_distance[19:10], result_links[27:20],
	// result_valid[28], still_queued[29], status[31:30], queued_count[42:32]
	output logic [47:0] m_tdata
);
	import bpq_pkg::*;
	`include "assert_macros.svh"

	localparam int ID_W  = $clog2(NODE_COUNT);
	localparam int PTR_W = $clog2(NODE_COUNT+1);
	localparam int B_W   = $clog2(TOP_BUCKET+1);
	localparam int REC_W = 2 + B_W + HOP_W;
	localparam int CLR_N = (NODE_COUNT > TOP_BUCKET+1) ? NODE_COUNT : TOP_BUCKET+1;
	localparam int CLR_W = $clog2(CLR_N);
	localparam logic [PTR_W-1:0] NIL  = PTR_W'(NODE_COUNT);
	localparam logic [B_W-1:0]   TOPB = B_W'(TOP_BUCKET);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_UL2   = 4'd3;
	localparam logic [3:0] S_PUSHW = 4'd4;
	localparam logic [3:0] S_FIXP  = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_DUL   = 4'd7;
	localparam logic [3:0] S_DFIX  = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0]       state_q;
	logic [CLR_W-1:0] clr_q;
	logic [1:0]       cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [9:0]       rawid_q;
	logic [9:0]       dist_q;
	logic [7:0]       links_q;
	logic             phase_q;
	logic [B_W-1:0]   b_q;
	logic [ID_W-1:0]  n_q;
	logic [PTR_W-1:0] nx_q;
	logic [PTR_W-1:0] pv_q;
	logic [PTR_W-1:0] hd_q;
	logic [B_W-1:0]   min_q;
	logic [PTR_W-1:0] cnt_q;
	logic [B_W-1:0]   scan_b_q;
	logic [B_W-1:0]   rd_b_s1;
	logic             rdv_s1;
	logic [9:0]       r_id_q;
	logic [9:0]       r_dist_q;
	logic [7:0]       r_links_q;
	logic             r_valid_q;
	logic             r_queued_q;
	logic [1:0]       st_q;
	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;

	// Memory ports
	logic [ID_W-1:0]  node_raddr, node_waddr;
	node_we_t         node_we;
	logic [REC_W-1:0] node_wrec, node_rrec;
	logic [PTR_W-1:0] node_wnext, node_wprev, node_rnext, node_rprev;
	logic [B_W-1:0]   head_raddr, head_waddr;
	logic             head_we;
	logic [PTR_W-1:0] head_wdata, head_rdata;

	logic [1:0]       in_cmd;
	logic [9:0]       in_id, in_dist;
	logic [7:0]       in_links;
	logic             in_id_ok, dist_ok, accept, found, out_load;
	logic             rd_present, rd_queued;
	logic [B_W-1:0]   rd_dist, dist_b;
	logic [HOP_W-1:0] rd_hops;

	assign in_cmd   = s_tuser;
	assign in_id    = s_tdata[9:0];
	assign in_dist  = s_tdata[19:10];
	assign in_links = s_tdata[27:20];
	assign in_id_ok = 32'(in_id) < NODE_COUNT;
	assign dist_ok  = 32'(dist_q) <= TOP_BUCKET;
	assign dist_b   = B_W'(dist_q);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign found    = rdv_s1 && ((head_rdata != NIL) || (rd_b_s1 == TOPB));
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	assign rd_present = node_rrec[REC_W-1];
	assign rd_queued  = node_rrec[REC_W-2];
	assign rd_dist    = node_rrec[HOP_W +: B_W];
	assign rd_hops    = node_rrec[HOP_W-1:0];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	bpq_store #(
		.NODE_COUNT (NODE_COUNT),
		.TOP_BUCKET (TOP_BUCKET)
	) u_store (
		.clk        (clk),
		.node_raddr (node_raddr),
		.node_waddr (node_waddr),
		.node_we    (node_we),
		.node_wrec  (node_wrec),
		.node_wnext (node_wnext),
		.node_wprev (node_wprev),
		.node_rrec  (node_rrec),
		.node_rnext (node_rnext),
		.node_rprev (node_rprev),
		.head_raddr (head_raddr),
		.head_waddr (head_waddr),
		.head_we    (head_we),
		.head_wdata (head_wdata),
		.head_rdata (head_rdata)
	);

	// Drive memory accesses for the current step
	always_comb begin
		node_raddr = '0;
		node_waddr = '0;
		node_we    = '0;
		node_wrec  = '0;
		node_wnext = NIL;
		node_wprev = NIL;
		head_raddr = '0;
		head_waddr = '0;
		head_we    = 1'b0;
		head_wdata = NIL;
		unique case (state_q)
			S_CLR: begin
				node_waddr  = ID_W'(clr_q);
				node_we.rec = (32'(clr_q) < NODE_COUNT);
				head_waddr  = B_W'(clr_q);
				head_we     = (32'(clr_q) <= TOP_BUCKET);
			end
			S_IDLE: begin
				node_raddr = ID_W'(in_id);
				head_raddr = B_W'(in_dist);
			end
			S_RD: begin
				if (cmd_q == CMD_INSERT && dist_ok && !rd_present) begin
					node_waddr = id_q;
					node_we    = '{rec: 1'b1, nxt: 1'b1, prv: 1'b1};
					node_wrec  = {1'b1, 1'b1, dist_b, links_q};
					node_wnext = head_rdata;
					head_waddr = dist_b;
					head_we    = 1'b1;
					head_wdata = PTR_W'(id_q);
				end else if (cmd_q == CMD_DECREASE && rd_present && dist_ok) begin
					if (!rd_queued) begin
						node_waddr  = id_q;
						node_we.rec = 1'b1;
						node_wrec   = {1'b1, 1'b0, dist_b, links_q};
					end else if (node_rprev == NIL) begin
						head_waddr = rd_dist;
						head_we    = 1'b1;
						head_wdata = node_rnext;
					end else begin
						node_waddr  = ID_W'(node_rprev);
						node_we.nxt = 1'b1;
						node_wnext  = node_rnext;
					end
				end
			end
			S_UL2: begin
				node_waddr  = ID_W'(nx_q);
				node_we.prv = (nx_q != NIL);
				node_wprev  = pv_q;
				head_raddr  = dist_b;
			end
			S_PUSHW: begin
				node_waddr = id_q;
				node_we    = '{rec: 1'b1, nxt: 1'b1, prv: 1'b1};
				node_wrec  = {1'b1, 1'b1, dist_b, links_q};
				node_wnext = head_rdata;
				head_waddr = dist_b;
				head_we    = 1'b1;
				head_wdata = PTR_W'(id_q);
			end
			S_FIXP: begin
				node_waddr  = ID_W'(hd_q);
				node_we.prv = 1'b1;
				node_wprev  = PTR_W'(id_q);
			end
			S_SCAN: begin
				head_raddr = scan_b_q;
				node_raddr = ID_W'(head_rdata);
			end
			S_DUL: begin
				node_waddr  = n_q;
				node_we.rec = 1'b1;
				node_wrec   = {1'b1, 1'b0, rd_dist, rd_hops};
				head_waddr  = b_q;
				head_we     = 1'b1;
				head_wdata  = node_rnext;
			end
			S_DFIX: begin
				node_waddr  = ID_W'(nx_q);
				node_we.prv = (nx_q != NIL);
				node_wprev  = NIL;
			end
			default: begin
			end
		endcase
	end

	// Sequence the commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			min_q    <= TOPB;
			cnt_q    <= '0;
			rdv_s1   <= 1'b0;
			phase_q  <= 1'b0;
			scan_b_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CLR_N - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (in_cmd == CMD_DELETE) begin
							scan_b_q <= min_q;
							rdv_s1   <= 1'b0;
							phase_q  <= 1'b0;
							state_q  <= S_SCAN;
						end else if (!in_id_ok) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_OUT;
					if (cmd_q == CMD_INSERT && dist_ok && !rd_present) begin
						cnt_q <= cnt_q + 1'b1;
						if (dist_b < min_q) begin
							min_q <= dist_b;
						end
						if (head_rdata != NIL) begin
							state_q <= S_FIXP;
						end
					end else if (cmd_q == CMD_DECREASE && rd_present && dist_ok &&
							rd_queued) begin
						state_q <= S_UL2;
					end
				end
				S_UL2: begin
					state_q <= S_PUSHW;
				end
				S_PUSHW: begin
					if (dist_b < min_q) begin
						min_q <= dist_b;
					end
					state_q <= (head_rdata != NIL) ? S_FIXP : S_OUT;
				end
				S_FIXP: begin
					state_q <= S_OUT;
				end
				S_SCAN: begin
					rd_b_s1  <= scan_b_q;
					rdv_s1   <= 1'b1;
					scan_b_q <= (scan_b_q == TOPB) ? TOPB : scan_b_q + 1'b1;
					if (found) begin
						rdv_s1 <= 1'b0;
						if (phase_q) begin
							min_q   <= rd_b_s1;
							state_q <= S_OUT;
						end else if (head_rdata == NIL) begin
							min_q   <= TOPB;
							state_q <= S_OUT;
						end else begin
							state_q <= S_DUL;
						end
					end
				end
				S_DUL: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= S_DFIX;
				end
				S_DFIX: begin
					scan_b_q <= b_q;
					rdv_s1   <= 1'b0;
					phase_q  <= 1'b1;
					state_q  <= S_SCAN;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request and build the result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_cmd;
			id_q       <= ID_W'(in_id);
			rawid_q    <= in_id;
			dist_q     <= in_dist;
			links_q    <= in_links;
			r_id_q     <= '0;
			r_dist_q   <= '0;
			r_links_q  <= '0;
			r_valid_q  <= 1'b0;
			r_queued_q <= 1'b0;
			st_q       <= ST_OK;
			if (in_cmd != CMD_DELETE && !in_id_ok) begin
				st_q <= ST_ABSENT;
				if (in_cmd == CMD_LOOKUP) begin
					r_id_q <= in_id;
				end
			end
		end
		case (state_q)
			S_RD: begin
				nx_q <= node_rnext;
				pv_q <= node_rprev;
				hd_q <= head_rdata;
				case (cmd_q)
					CMD_INSERT: begin
						if (!dist_ok) begin
							st_q <= ST_RANGE;
						end else if (rd_present) begin
							st_q <= ST_DUP;
						end
					end
					CMD_DECREASE: begin
						if (!rd_present) begin
							st_q <= ST_ABSENT;
						end else if (!dist_ok) begin
							st_q <= ST_RANGE;
						end
					end
					CMD_LOOKUP: begin
						r_id_q <= rawid_q;
						if (rd_present) begin
							r_dist_q   <= 10'(rd_dist);
							r_links_q  <= rd_hops;
							r_valid_q  <= 1'b1;
							r_queued_q <= rd_queued;
						end else begin
							st_q <= ST_ABSENT;
						end
					end
					default: begin
					end
				endcase
			end
			S_PUSHW: begin
				hd_q <= head_rdata;
			end
			S_SCAN: begin
				if (found && !phase_q) begin
					b_q <= rd_b_s1;
					n_q <= ID_W'(head_rdata);
					if (head_rdata == NIL) begin
						st_q <= ST_ABSENT;
					end
				end
			end
			S_DUL: begin
				nx_q      <= node_rnext;
				r_id_q    <= 10'(n_q);
				r_dist_q  <= 10'(rd_dist);
				r_links_q <= rd_hops;
				r_valid_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {5'd0, 11'(cnt_q), st_q, r_queued_q, r_valid_q,
				r_links_q, r_dist_q, r_id_q};
		end
	end

	`ASSERT_IMPLY(a_count_bound, 1'b1, 32'(cnt_q) <= NODE_COUNT)
	`ASSERT_NEXT(a_one_request, accept, !s_tready)
	`ASSERT_IMPLY(a_dup_no_result, m_tvalid_q && (m_tdata_q[31:30] == ST_DUP), !m_tdata_q[28])

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bucket queue: a directed table of requests,
// then random request mixes checked against a behavioral queue predictor.
// ---------------------------------------------------------------------------
module tb_top;
	import bpq_pkg::*;

	localparam int NODES   = DEF_NODE_COUNT;
	localparam int TOPB    = DEF_TOP_BUCKET;
	localparam int NIL     = NODES;
	localparam int WD_MAX  = 20000;
	localparam int N_RAND  = 1130;

	// Members listed from the highest bit down to match the result word
	typedef struct packed {
		logic [10:0] count;
		logic [1:0]  status;
		logic        queued;
		logic        valid;
		logic [7:0]  hops;
		logic [9:0]  dst;
		logic [9:0]  id;
	} qres_t;

	typedef struct {
		logic [1:0] cmd;
		logic [9:0] id;
		logic [9:0] dst;
		logic [7:0] hops;
		bit         has_exp;
		qres_t      exp_res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	// Predictor state
	bit          pr_present [NODES];
	bit          pr_queued [NODES];
	int          pr_dist [NODES];
	int          pr_hops [NODES];
	int          pr_next [NODES];
	int          pr_prev [NODES];
	int          pr_head [TOPB + 1];
	int          pr_min;
	int          pr_count;

	qres_t       pending_results[$];
	int          errors = 0;
	int          n_req = 0;
	int          n_res = 0;
	int          n_removed = 0;
	int          idle_cycles = 0;
	bit          stim_done = 0;

	bucket_priority_queue_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void unlink_entry(int n);
		int nx, pv;
		nx = pr_next[n];
		pv = pr_prev[n];
		if (pv == NIL)
			pr_head[pr_dist[n]] = nx;
		else
			pr_next[pv] = nx;
		if (nx != NIL)
			pr_prev[nx] = pv;
		pr_next[n] = NIL;
		pr_prev[n] = NIL;
		pr_queued[n] = 0;
	endfunction

	function automatic void push_entry(int n);
		int b;
		b = pr_dist[n];
		pr_prev[n] = NIL;
		pr_next[n] = pr_head[b];
		if (pr_head[b] != NIL)
			pr_prev[pr_head[b]] = n;
		pr_head[b] = n;
		pr_queued[n] = 1;
		if (b < pr_min)
			pr_min = b;
	endfunction

	function automatic int scan_up(int from);
		for (int b = from; b < TOPB; b++)
			if (pr_head[b] != NIL)
				return b;
		return TOPB;
	endfunction

	// Advance the predictor by one request and return its result
	function automatic qres_t queue_step(logic [1:0] cmd, int id, int dst, int hops);
		qres_t r;
		int b, n;
		r = '0;
		if (cmd == CMD_DELETE) begin
			b = scan_up(pr_min);
			n = pr_head[b];
			if (n != NIL) begin
				unlink_entry(n);
				if (pr_count > 0)
					pr_count--;
				pr_min = scan_up(b);
				r.id = 10'(n);
				r.dst = 10'(pr_dist[n]);
				r.hops = 8'(pr_hops[n]);
				r.valid = 1;
			end else begin
				pr_min = TOPB;
				r.status = ST_ABSENT;
			end
		end else if (cmd == CMD_INSERT) begin
			if (dst > TOPB)
				r.status = ST_RANGE;
			else if (pr_present[id])
				r.status = ST_DUP;
			else begin
				pr_present[id] = 1;
				pr_dist[id] = dst;
				pr_hops[id] = hops;
				push_entry(id);
				pr_count++;
			end
		end else if (cmd == CMD_DECREASE) begin
			if (!pr_present[id])
				r.status = ST_ABSENT;
			else if (dst > TOPB)
				r.status = ST_RANGE;
			else if (!pr_queued[id]) begin
				pr_dist[id] = dst;
				pr_hops[id] = hops;
			end else begin
				unlink_entry(id);
				pr_dist[id] = dst;
				pr_hops[id] = hops;
				push_entry(id);
			end
		end else begin
			r.id = 10'(id);
			if (pr_present[id]) begin
				r.dst = 10'(pr_dist[id]);
				r.hops = 8'(pr_hops[id]);
				r.valid = 1;
				r.queued = pr_queued[id];
			end else
				r.status = ST_ABSENT;
		end
		r.count = 11'(pr_count);
		return r;
	endfunction

	// Drive one request with random bursts and gaps; predict it on acceptance
	task automatic send_request(logic [1:0] cmd, logic [9:0] id, logic [9:0] dst,
			logic [7:0] hops, bit has_exp, qres_t exp_res);
		qres_t p;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, hops, dst, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		p = queue_step(cmd, id, dst, hops);
		if (cmd == CMD_DELETE && p.valid)
			n_removed++;
		if (has_exp && p != exp_res) begin
			$error("directed row %0d: table %h, predictor %h", n_req, exp_res, p);
			errors++;
		end
		pending_results = {pending_results, p};
		n_req++;
		@(negedge clk);
		// Gap between bursts
		if ($urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Receiver stall pattern: long ready stretches, bursts of stall
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			mode = $urandom_range(0, 99);
			if (mode < 70)
				m_tready <= 1'b1;
			else if (mode < 95)
				m_tready <= 1'($urandom_range(0, 1));
			else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		qres_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[42:0];
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_res++;
				if (got.id !== want.id) begin
					$error("result_id: expected %0d, got %0d", want.id, got.id);
					errors++;
				end
				if (got.dst !== want.dst) begin
					$error("result_distance: expected %0d, got %0d", want.dst, got.dst);
					errors++;
				end
				if (got.hops !== want.hops) begin
					$error("result_links: expected %0d, got %0d", want.hops, got.hops);
					errors++;
				end
				if (got.valid !== want.valid) begin
					$error("result_valid: expected %0d, got %0d", want.valid, got.valid);
					errors++;
				end
				if (got.queued !== want.queued) begin
					$error("still_queued: expected %0d, got %0d", want.queued, got.queued);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("queued_count: expected %0d, got %0d", want.count, got.count);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_MAX) begin
			$display("watchdog: no progress for %0d cycles", WD_MAX);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic qres_t mk(int id, int dst, int hops, bit v, bit q,
			logic [1:0] st, int cnt);
		qres_t r;
		r.id = 10'(id); r.dst = 10'(dst); r.hops = 8'(hops); r.valid = v;
		r.queued = q; r.status = st; r.count = 11'(cnt);
		return r;
	endfunction

	function automatic dir_row_t row(logic [1:0] c, int id, int dst, int hops,
			bit he, qres_t e);
		dir_row_t d;
		d.cmd = c; d.id = 10'(id); d.dst = 10'(dst); d.hops = 8'(hops);
		d.has_exp = he; d.exp_res = e;
		return d;
	endfunction

	// Random request with a mix that keeps the queue populated
	task automatic random_request(int pool);
		int sel, id, dst;
		logic [1:0] cmd;
		sel = $urandom_range(0, 99);
		id = $urandom_range(0, pool - 1);
		if ($urandom_range(0, 19) == 0)
			id = $urandom_range(0, NODES - 1);
		dst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TOPB) : $urandom_range(0, 40);
		if (sel < 38)
			cmd = CMD_INSERT;
		else if (sel < 58)
			cmd = CMD_DECREASE;
		else if (sel < 83)
			cmd = CMD_DELETE;
		else
			cmd = CMD_LOOKUP;
		send_request(cmd, 10'(id), 10'(dst), 8'($urandom), 0, '0);
	endtask

	initial begin
		dir_row_t dir_rows[$];
		int pool;
		for (int i = 0; i < NODES; i++) begin
			pr_present[i] = 0; pr_queued[i] = 0; pr_dist[i] = 0; pr_hops[i] = 0;
			pr_next[i] = NIL; pr_prev[i] = NIL;
		end
		for (int b = 0; b <= TOPB; b++)
			pr_head[b] = NIL;
		pr_min = TOPB;
		pr_count = 0;

		// Directed requests; typed results only where obvious
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 1, mk(0, 0, 0, 0, 0, ST_ABSENT, 0))};
		dir_rows = {dir_rows, row(CMD_LOOKUP, 1023, 0, 0, 1,
			mk(1023, 0, 0, 0, 0, ST_ABSENT, 0))};
		dir_rows = {dir_rows, row(CMD_DECREASE, 5, 3, 1, 1, mk(0, 0, 0, 0, 0, ST_ABSENT, 0))};
		dir_rows = {dir_rows, row(CMD_INSERT, 0, 1023, 255, 1, mk(0, 0, 0, 0, 0, ST_OK, 1))};
		dir_rows = {dir_rows, row(CMD_INSERT, 1023, 0, 0, 1, mk(0, 0, 0, 0, 0, ST_OK, 2))};
		dir_rows = {dir_rows, row(CMD_INSERT, 0, 4, 4, 1, mk(0, 0, 0, 0, 0, ST_DUP, 2))};
		dir_rows = {dir_rows, row(CMD_LOOKUP, 0, 0, 0, 1,
			mk(0, 1023, 255, 1, 1, ST_OK, 2))};
		dir_rows = {dir_rows, row(CMD_INSERT, 7, 10, 7, 0, '0)};
		dir_rows = {dir_rows, row(CMD_INSERT, 8, 10, 8, 0, '0)};
		dir_rows = {dir_rows, row(CMD_INSERT, 9, 10, 9, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DECREASE, 8, 500, 88, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DECREASE, 1023, 20, 170, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DECREASE, 9, 2, 66, 0, '0)};
		dir_rows = {dir_rows, row(CMD_LOOKUP, 9, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_INSERT, 9, 1, 1, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_DELETE, 0, 0, 0, 0, '0)};
		dir_rows = {dir_rows, row(CMD_LOOKUP, 8, 0, 0, 0, '0)};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_request(dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].dst, dir_rows[i].hops,
				dir_rows[i].has_exp, dir_rows[i].exp_res);

		// Random phases: small id pools for collisions, then the full range
		for (int i = 0; i < N_RAND; i++) begin
			pool = (i < N_RAND / 2) ? 48 : ((i < 3 * N_RAND / 4) ? 256 : NODES);
			random_request(pool);
		end
		// Drain so the last requests are deletes down to an empty queue
		while (pr_count > 0)
			send_request(CMD_DELETE, 10'($urandom), 10'($urandom), 8'($urandom), 0, '0);
		send_request(CMD_DELETE, 0, 0, 0, 0, '0);
		s_tvalid <= 1'b0;
		stim_done = 1;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d requests, checked %0d results, %0d nodes removed by delete.",
			n_req, n_res, n_removed);
		if (errors == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
